>>> rtl/dct_pkg.sv
// Package for the 8x8 DCT block: constants, types, cosine basis function.
package dct_pkg;

  localparam int unsigned BlockSize  = 64;
  localparam int unsigned InterFrac  = 8;
  localparam int unsigned InterWidth = 24;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PASS1,
    ST_PASS2
  } engine_state_e;

  typedef struct packed {
    logic mode;
  } job_t;

  // c/2 * cos(m*pi/16) in Q2.30
  function automatic logic [31:0] half_cos_q30(input logic [3:0] m);
    logic [31:0] r;
    case (m)
      4'd0: r = 32'd536870912;
      4'd1: r = 32'd526555088;
      4'd2: r = 32'd496004047;
      4'd3: r = 32'd446391849;
      4'd4: r = 32'd379625062;
      4'd5: r = 32'd298269498;
      4'd6: r = 32'd205451603;
      4'd7: r = 32'd104738319;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Basis B[k][n] in Q1.frac, returned as 20-bit signed.
  function automatic logic signed [19:0] basis(input logic [2:0] k, input logic [2:0] n,
                                              input int unsigned frac);
    logic [4:0]  m;
    logic [31:0] mag;
    logic [32:0] q;
    logic        neg;
    neg = 1'b0;
    if (k == 3'd0) begin
      mag = half_cos_q30(4'd4);
    end else begin
      m = 5'(({2'b0, n, 1'b1}) * {3'b0, k});
      if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
      if (m > 5'd8) begin
        m = 5'd16 - m;
        neg = 1'b1;
      end
      mag = half_cos_q30(m[3:0]);
    end
    q = ({1'b0, mag} + (33'd1 << (29 - frac))) >> (30 - frac);
    return neg ? -$signed(20'(q)) : $signed(20'(q));
  endfunction

endpackage

>>> rtl/dct_front.sv
// Front end: collects 64 elements into the input store and queues a job per block.
module dct_front #(
  parameter int unsigned VALUE_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  logic                          mode_i,
  input  logic [5:0]                    rd_addr_i,
  output logic signed [VALUE_WIDTH-1:0] rd_data_o,
  input  logic                          rd_done_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output dct_pkg::job_t                 job_o
);

  logic signed [VALUE_WIDTH-1:0] mem_q [dct_pkg::BlockSize];
  logic [5:0] fill_q, fill_d;
  logic       busy_q, busy_d;
  logic       sent_q, sent_d;
  logic       acc;

  // Store is held until the back end finished reading it (busy).
  assign in_ready_o = !busy_q;
  assign acc = in_valid_i && in_ready_o;
  assign job_valid_o = busy_q && !sent_q;

  always_comb begin
    fill_d = fill_q;
    busy_d = busy_q;
    sent_d = sent_q;
    if (job_valid_o && job_ready_i) sent_d = 1'b1;
    if (rd_done_i) begin
      busy_d = 1'b0;
      sent_d = 1'b0;
    end
    if (acc) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'd63) busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      busy_q     <= 1'b0;
      sent_q     <= 1'b0;
      job_o.mode <= 1'b0;
    end else begin
      fill_q <= fill_d;
      busy_q <= busy_d;
      sent_q <= sent_d;
      if (acc && fill_q == 6'd63) job_o.mode <= mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[fill_q] <= sample_value_i;
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> rtl/dct_back.sv
// Back end: two-pass row-column transform on one shared MAC, results to an output register.
module dct_back #(
  parameter int unsigned VALUE_WIDTH   = 12,
  parameter int unsigned COS_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  dct_pkg::job_t                 job_i,
  output logic [5:0]                    rd_addr_o,
  input  logic signed [VALUE_WIDTH-1:0] rd_data_i,
  output logic                          rd_done_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] result_value_o,
  output logic                          last_of_block_o
);

  localparam int unsigned IW  = dct_pkg::InterWidth;
  localparam int unsigned AW  = IW + 20 + 3;
  localparam int unsigned Sh1 = COS_FRAC_BITS - dct_pkg::InterFrac;
  localparam int unsigned Sh2 = COS_FRAC_BITS + dct_pkg::InterFrac;

  dct_pkg::engine_state_e state_q, state_d;
  logic [5:0]  idx_q, idx_d;     // output element index r*8+k
  logic [3:0]  j_q, j_d;         // tap counter, 10 = finish
  logic        mode_q;
  logic        job_taken;
  logic signed [AW-1:0] acc_q;
  logic signed [IW-1:0] tmem_q [dct_pkg::BlockSize];
  logic signed [IW-1:0] trd_q;
  logic signed [19:0]   coef_q;
  logic                 mac_en_q;
  logic [5:0]           t_addr;
  logic signed [IW-1:0] opa;
  logic signed [IW+19:0] prod_n;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] mag, rnd;
  logic signed [AW-1:0] hi1, lo1, hi2, lo2;
  logic                 finish;

  assign job_ready_o = (state_q == dct_pkg::ST_FILL) && !out_valid_o;
  assign job_taken   = job_valid_i && job_ready_o;
  assign rd_addr_o   = {idx_q[5:3], j_q[2:0]};
  assign t_addr      = {j_q[2:0], idx_q[5:3]};
  assign finish      = (j_q == 4'd10);
  // input store no longer needed once pass one is done
  assign rd_done_o   = (state_q == dct_pkg::ST_PASS1) && finish && (idx_q == 6'd63);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    j_d     = j_q;
    case (state_q)
      dct_pkg::ST_FILL: begin
        if (job_taken) begin
          state_d = dct_pkg::ST_PASS1;
          idx_d   = '0;
          j_d     = '0;
        end
      end
      dct_pkg::ST_PASS1: begin
        j_d = j_q + 4'd1;
        if (finish) begin
          j_d   = '0;
          idx_d = idx_q + 6'd1;
          if (idx_q == 6'd63) state_d = dct_pkg::ST_PASS2;
        end
      end
      dct_pkg::ST_PASS2: begin
        if (!(finish && out_valid_o)) j_d = j_q + 4'd1;
        if (finish && !out_valid_o) begin
          j_d   = '0;
          idx_d = idx_q + 6'd1;
          if (idx_q == 6'd63) state_d = dct_pkg::ST_FILL;
        end
      end
      default: state_d = dct_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dct_pkg::ST_FILL;
      idx_q    <= '0;
      j_q      <= '0;
      mode_q   <= 1'b0;
      mac_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      j_q      <= j_d;
      if (job_taken) mode_q <= job_i.mode;
      mac_en_q <= (state_q != dct_pkg::ST_FILL) && (j_q < 4'd8);
    end
  end

  // Stage 1: operand fetch (input store read in front, transpose read, coefficient)
  always_ff @(posedge clk_i) begin
    trd_q  <= tmem_q[t_addr];
    coef_q <= mode_q ? dct_pkg::basis(j_q[2:0], idx_q[2:0], COS_FRAC_BITS)
                     : dct_pkg::basis(idx_q[2:0], j_q[2:0], COS_FRAC_BITS);
  end

  // Stage 2: multiply-accumulate
  assign opa    = (state_q == dct_pkg::ST_PASS1) ? IW'(rd_data_i) : trd_q;
  assign prod_n = opa * coef_q;
  assign prod   = AW'(prod_n);

  always_ff @(posedge clk_i) begin
    if (j_q == 4'd0 && !(finish)) acc_q <= '0;
    else if (mac_en_q && j_q != 4'd10) acc_q <= acc_q + prod;
  end

  // Rounding, ties away from zero
  always_comb begin
    mag = acc_q[AW-1] ? -acc_q : acc_q;
    if (state_q == dct_pkg::ST_PASS1)
      rnd = (mag + (AW'(1) << (Sh1 - 1))) >>> Sh1;
    else
      rnd = (mag + (AW'(1) << (Sh2 - 1))) >>> Sh2;
    if (acc_q[AW-1]) rnd = -rnd;
    hi1 = (AW'(1) <<< (IW - 1)) - AW'(1);
    lo1 = -hi1 - AW'(1);
    hi2 = (AW'(1) <<< (VALUE_WIDTH - 1)) - AW'(1);
    lo2 = -hi2 - AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dct_pkg::ST_PASS1 && finish) begin
      if (rnd > hi1)      tmem_q[idx_q] <= hi1[IW-1:0];
      else if (rnd < lo1) tmem_q[idx_q] <= lo1[IW-1:0];
      else                tmem_q[idx_q] <= rnd[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == dct_pkg::ST_PASS2 && finish && !out_valid_o) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dct_pkg::ST_PASS2 && finish && !out_valid_o) begin
      last_of_block_o <= (idx_q == 6'd63);
      if (rnd > hi2)      result_value_o <= hi2[VALUE_WIDTH-1:0];
      else if (rnd < lo2) result_value_o <= lo2[VALUE_WIDTH-1:0];
      else                result_value_o <= rnd[VALUE_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/dct_8x8_forward_inverse.sv
// Top level of the 8x8 forward/inverse DCT.
// Each element of each pass takes 8 taps on one shared MAC, then pipeline drain and write-back.
// Inputs stall from the 64th transfer until pass one ends, so the next block can be collected
// during pass two; a stalled result holds pass two.
// Reset: rst_ni asynchronous active low clears counters, handshakes and mode; stores are
// not cleared.
module dct_8x8_forward_inverse #(
  parameter int unsigned VALUE_WIDTH   = 12,
  parameter int unsigned COS_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          transform_mode_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] result_value_o,
  output logic                          last_of_block_o
);

  logic                          mode_q;
  logic                          job_valid, job_ready;
  dct_pkg::job_t                 job;
  logic [5:0]                    rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic                          rd_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_valid_i) mode_q <= transform_mode_i;
  end

  dct_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_value_i,
    .mode_i(mode_q), .rd_addr_i(rd_addr), .rd_data_o(rd_data), .rd_done_i(rd_done),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  dct_back #(.VALUE_WIDTH(VALUE_WIDTH), .COS_FRAC_BITS(COS_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data), .rd_done_o(rd_done), .out_valid_o, .out_ready_i,
    .result_value_o, .last_of_block_o
  );

endmodule

>>> rtl/dct_checker.sv
// Port-level checker for the DCT top level, with its bind.
module dct_checker #(
  parameter int unsigned VALUE_WIDTH = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [VALUE_WIDTH-1:0] result_value_o,
  input logic                   last_of_block_o,
  input logic                   cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("output not held");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("results closer than transform allows");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({result_value_o, last_of_block_o}))
    else $error("unknown result payload");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg stalled");

endmodule

bind dct_8x8_forward_inverse dct_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .result_value_o, .last_of_block_o,
  .cfg_ready_o
);
